### hw/rtl/extra_load_store_decode_agu_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the extra load/store decode and address unit
// Shared property wrappers clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef EXTRA_LOAD_STORE_DECODE_AGU_UNIT_ASSERT_SVH
`define EXTRA_LOAD_STORE_DECODE_AGU_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ELSDU_CHECK(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ELSDU_CHECK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/elsdu_pkg.sv
// ----------------------------------------------------------------------------
// elsdu_pkg
// Types and constants shared by the extra load/store decode and address unit.
// ----------------------------------------------------------------------------
package elsdu_pkg;

  typedef enum logic [2:0] {
    KIND_ERR   = 3'd0,
    KIND_STRH  = 3'd1,
    KIND_LDRH  = 3'd2,
    KIND_LDRD  = 3'd3,
    KIND_LDRSB = 3'd4,
    KIND_STRD  = 3'd5,
    KIND_LDRSH = 3'd6
  } op_kind_t;

  // Values of the op2 field in bits 6:5.
  localparam logic [1:0] OP2_NONE = 2'b00;
  localparam logic [1:0] OP2_HALF = 2'b01;
  localparam logic [1:0] OP2_DBL_SB = 2'b10;
  localparam logic [1:0] OP2_DBL_SH = 2'b11;

  localparam logic [3:0] REG_PC = 4'hF;
  localparam logic [31:0] DWORD_STEP = 32'd4;

  // Configuration register indexes.
  localparam logic CFG_UNALIGNED_OK   = 1'b0;
  localparam logic CFG_ARCH_BEFORE_V6 = 1'b1;

  typedef struct packed {
    logic unaligned_ok;
    logic arch_before_v6;
  } cfg_t;

  typedef struct packed {
    op_kind_t    op_kind;
    logic        execute;
    logic [31:0] address;
    logic [31:0] second_address;
    logic [3:0]  dest_reg;
    logic [3:0]  dest2_reg;
    logic [3:0]  base_reg;
    logic        writeback;
    logic [31:0] writeback_value;
    logic        unpredictable;
    logic        align_fault;
    logic        literal_form;
  } result_t;

endpackage

### hw/rtl/elsdu_in_if.sv
// ----------------------------------------------------------------------------
// elsdu_in_if
// Instruction channel: valid/ready handshake with the word and operands.
// ----------------------------------------------------------------------------
interface elsdu_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] instr;
  logic        cond_passed;
  logic [31:0] base_value;
  logic [31:0] index_value;

  modport source (output valid, output instr, output cond_passed,
                  output base_value, output index_value, input ready);
  modport sink (input valid, input instr, input cond_passed,
                input base_value, input index_value, output ready);
endinterface

### hw/rtl/elsdu_out_if.sv
// ----------------------------------------------------------------------------
// elsdu_out_if
// Result channel: valid/ready handshake with the decoded access.
// ----------------------------------------------------------------------------
interface elsdu_out_if;
  logic                 valid;
  logic                 ready;
  elsdu_pkg::op_kind_t  op_kind;
  logic                 execute;
  logic [31:0]          address;
  logic [31:0]          second_address;
  logic [3:0]           dest_reg;
  logic [3:0]           dest2_reg;
  logic [3:0]           base_reg;
  logic                 writeback;
  logic [31:0]          writeback_value;
  logic                 unpredictable;
  logic                 align_fault;
  logic                 literal_form;

  modport source (output valid, output op_kind, output execute, output address,
                  output second_address, output dest_reg, output dest2_reg,
                  output base_reg, output writeback, output writeback_value,
                  output unpredictable, output align_fault, output literal_form,
                  input ready);
  modport sink (input valid, input op_kind, input execute, input address,
                input second_address, input dest_reg, input dest2_reg,
                input base_reg, input writeback, input writeback_value,
                input unpredictable, input align_fault, input literal_form,
                output ready);
endinterface

### hw/rtl/elsdu_decode.sv
// ----------------------------------------------------------------------------
// elsdu_decode
// Combinational decode, address generation and register checks for one word.
// ----------------------------------------------------------------------------
module elsdu_decode (
  input  logic [31:0]          instr,
  input  logic                 cond_passed,
  input  logic [31:0]          base_value,
  input  logic [31:0]          index_value,
  input  elsdu_pkg::cfg_t      cfg,
  output elsdu_pkg::result_t   result
);

  logic [1:0]          op2;
  logic                immf, load, pre, up, wbit;
  logic [3:0]          rn, rt, rm, rt2;
  logic                dec_err, dbl, half, literal, wback, unp, fault;
  elsdu_pkg::op_kind_t kind;
  logic [31:0]         offset, oaddr, addr;

  assign op2  = instr[6:5];
  assign immf = instr[22];
  assign load = instr[20];
  assign pre  = instr[24];
  assign up   = instr[23];
  assign wbit = instr[21];
  assign rn   = instr[19:16];
  assign rt   = instr[15:12];
  assign rm   = instr[3:0];

  assign dec_err = (op2 == elsdu_pkg::OP2_NONE) || (instr[27:25] != 3'b000) ||
                   !instr[7] || !instr[4] || (!immf && (instr[11:8] != 4'h0));

  always_comb begin
    unique case (op2)
      elsdu_pkg::OP2_HALF:   kind = load ? elsdu_pkg::KIND_LDRH  : elsdu_pkg::KIND_STRH;
      elsdu_pkg::OP2_DBL_SB: kind = load ? elsdu_pkg::KIND_LDRSB : elsdu_pkg::KIND_LDRD;
      elsdu_pkg::OP2_DBL_SH: kind = load ? elsdu_pkg::KIND_LDRSH : elsdu_pkg::KIND_STRD;
      default:               kind = elsdu_pkg::KIND_ERR;
    endcase
  end

  assign dbl  = (kind == elsdu_pkg::KIND_LDRD) || (kind == elsdu_pkg::KIND_STRD);
  assign half = (kind == elsdu_pkg::KIND_STRH) || (kind == elsdu_pkg::KIND_LDRH) ||
                (kind == elsdu_pkg::KIND_LDRSH);
  assign rt2  = dbl ? (rt + 4'd1) : 4'd0;

  // Every form that reads memory, with the PC as base and an immediate offset.
  assign literal = immf && (rn == elsdu_pkg::REG_PC) &&
                   (kind != elsdu_pkg::KIND_STRH) && (kind != elsdu_pkg::KIND_STRD);

  assign offset = immf ? {24'd0, instr[11:8], rm} : index_value;
  assign oaddr  = up ? (base_value + offset) : (base_value - offset);
  assign addr   = pre ? oaddr : base_value;
  assign wback  = !pre || wbit;

  always_comb begin
    unp   = 1'b0;
    fault = 1'b0;
    if (dbl) begin
      unp = rt[0] || (!pre && wbit) || (rt2 == elsdu_pkg::REG_PC) ||
            (wback && ((rn == rt) || (rn == rt2))) ||
            (wback && (rn == elsdu_pkg::REG_PC)) ||
            (!immf && (rm == elsdu_pkg::REG_PC)) ||
            (!immf && (kind == elsdu_pkg::KIND_LDRD) && ((rm == rt) || (rm == rt2)));
      fault = (addr[1:0] != 2'b00);
    end else begin
      unp = (rt == elsdu_pkg::REG_PC) || (wback && (rn == rt)) ||
            (wback && (rn == elsdu_pkg::REG_PC)) ||
            (!immf && (rm == elsdu_pkg::REG_PC));
      fault = half && !cfg.unaligned_ok && addr[0];
    end
    if (!immf && cfg.arch_before_v6 && wback && (rm == rn)) begin
      unp = 1'b1;
    end
  end

  always_comb begin
    result = '0;
    if (!dec_err) begin
      result.op_kind   = kind;
      result.dest_reg  = rt;
      result.dest2_reg = rt2;
      result.base_reg  = rn;
      if (literal) begin
        result.literal_form = 1'b1;
      end else begin
        result.execute         = cond_passed;
        result.address         = addr;
        result.second_address  = dbl ? (addr + elsdu_pkg::DWORD_STEP) : 32'd0;
        result.writeback       = cond_passed && wback;
        result.writeback_value = oaddr;
        result.unpredictable   = cond_passed && unp;
        result.align_fault     = cond_passed && fault;
      end
    end
  end

endmodule

### hw/rtl/extra_load_store_decode_agu_unit.sv
// ----------------------------------------------------------------------------
// extra_load_store_decode_agu_unit
// Decode and address generation for the extra load/store instruction class.
// ----------------------------------------------------------------------------
// The unit takes one instruction word per cycle while in_ch.ready is high and
// returns its decoded access: the word and operands land in an input register,
// a single pass of decode logic and the 32-bit offset adder forms the result,
// and the result register drives the output channel. The offset adder and the
// address increment behind it set the cycle time. A stalled result does not
// stop a new word from being taken into the empty input stage. Configuration
// writes take effect on the next cycle.
module extra_load_store_decode_agu_unit (
  input  logic        clk,
  input  logic        rst_n,
  elsdu_in_if.sink    in_ch,
  elsdu_out_if.source out_ch,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic        cfg_wdata
);

  elsdu_pkg::cfg_t    cfg_r;
  logic               s1_valid_r, out_valid_r;
  logic [31:0]        instr_r, base_r, index_r;
  logic               cond_r;
  elsdu_pkg::result_t dec_result;
  elsdu_pkg::result_t result_r;
  logic               out_free, s1_free;

  assign out_free    = !out_valid_r || out_ch.ready;
  assign s1_free     = !s1_valid_r || out_free;
  assign in_ch.ready = s1_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.unaligned_ok   <= 1'b1;
      cfg_r.arch_before_v6 <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        elsdu_pkg::CFG_UNALIGNED_OK:   cfg_r.unaligned_ok   <= cfg_wdata;
        elsdu_pkg::CFG_ARCH_BEFORE_V6: cfg_r.arch_before_v6 <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_free) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_free && in_ch.valid) begin
      instr_r <= in_ch.instr;
      cond_r  <= in_ch.cond_passed;
      base_r  <= in_ch.base_value;
      index_r <= in_ch.index_value;
    end
  end

  elsdu_decode u_decode (
    .instr       (instr_r),
    .cond_passed (cond_r),
    .base_value  (base_r),
    .index_value (index_r),
    .cfg         (cfg_r),
    .result      (dec_result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s1_valid_r) begin
      result_r <= dec_result;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.op_kind         = result_r.op_kind;
  assign out_ch.execute         = result_r.execute;
  assign out_ch.address         = result_r.address;
  assign out_ch.second_address  = result_r.second_address;
  assign out_ch.dest_reg        = result_r.dest_reg;
  assign out_ch.dest2_reg       = result_r.dest2_reg;
  assign out_ch.base_reg        = result_r.base_reg;
  assign out_ch.writeback       = result_r.writeback;
  assign out_ch.writeback_value = result_r.writeback_value;
  assign out_ch.unpredictable   = result_r.unpredictable;
  assign out_ch.align_fault     = result_r.align_fault;
  assign out_ch.literal_form    = result_r.literal_form;

`include "extra_load_store_decode_agu_unit_assert.svh"

  // A word in the input stage must not be dropped while the result is stalled.
  `ELSDU_CHECK_NEXT(a_s1_hold, s1_valid_r && out_valid_r && !out_ch.ready, s1_valid_r, "input stage lost a word while stalled")
  // Suppressed or literal accesses never write back, fault or flag registers.
  `ELSDU_CHECK(a_no_exec_side, out_valid_r && !result_r.execute, !result_r.writeback && !result_r.unpredictable && !result_r.align_fault, "side effect on a suppressed access")
  // Literal forms are never executed.
  `ELSDU_CHECK(a_literal_idle, out_valid_r && result_r.literal_form, !result_r.execute, "literal form marked for execution")
  // A decode error carries no register numbers.
  `ELSDU_CHECK(a_err_clear, out_valid_r && (result_r.op_kind == elsdu_pkg::KIND_ERR), (result_r.dest_reg == 4'd0) && (result_r.base_reg == 4'd0) && !result_r.execute, "decode error with live fields")

endmodule

### test/tb_extra_load_store_decode_agu_unit.sv
// ----------------------------------------------------------------------------
// tb_extra_load_store_decode_agu_unit
// Drives extra load/store instruction words with operands through the unit
// and checks every decoded access against a behavioral predictor. It runs a
// directed set of corner cases, then random words under four idle patterns
// and four register settings, with one long output hold-off.
// ----------------------------------------------------------------------------
module tb_extra_load_store_decode_agu_unit;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [31:0] instr;
    logic        cond_passed;
    logic [31:0] base_value;
    logic [31:0] index_value;
  } insn_word_t;

  localparam int HOLD_LEN = 64;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic cfg_index;
  logic cfg_wdata;

  elsdu_in_if  in_ch();
  elsdu_out_if out_ch();

  extra_load_store_decode_agu_unit i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  insn_word_t         pending_words[$];
  elsdu_pkg::result_t expected_decodes[$];
  insn_word_t         in_flight;

  logic model_uok;
  logic model_v6;
  int   send_idle_pct;
  int   recv_stall_pct;
  logic hold_start;
  int   hold_left;

  int fail_count;
  int words_accepted;
  int results_checked;
  int input_stall_cycles;
  int kind_tally[8];
  int unp_tally;
  int fault_tally;
  int literal_tally;

  always #5 clk = ~clk;

  // Expected decode of one word under the given register settings.
  function automatic elsdu_pkg::result_t decode_access(insn_word_t w, logic uok, logic v6);
    elsdu_pkg::result_t r;
    logic [31:0] ins;
    logic [1:0]  op2;
    logic        immf, ld, pre, up, wbit;
    logic [3:0]  rn, rt, rm, rt2;
    logic [31:0] off, oaddr, addr;
    logic        dbl, half, wback, unp, fault;
    r = '0;
    ins = w.instr;
    op2 = ins[6:5];
    immf = ins[22];
    ld = ins[20];
    pre = ins[24];
    up = ins[23];
    wbit = ins[21];
    rn = ins[19:16];
    rt = ins[15:12];
    rm = ins[3:0];
    if (op2 == elsdu_pkg::OP2_NONE || ins[27:25] != 3'b000 || !ins[7] || !ins[4] ||
        (!immf && ins[11:8] != 4'h0))
      return r;
    case (op2)
      elsdu_pkg::OP2_HALF:
        r.op_kind = ld ? elsdu_pkg::KIND_LDRH : elsdu_pkg::KIND_STRH;
      elsdu_pkg::OP2_DBL_SB:
        r.op_kind = ld ? elsdu_pkg::KIND_LDRSB : elsdu_pkg::KIND_LDRD;
      default:
        r.op_kind = ld ? elsdu_pkg::KIND_LDRSH : elsdu_pkg::KIND_STRD;
    endcase
    dbl = (r.op_kind == elsdu_pkg::KIND_LDRD || r.op_kind == elsdu_pkg::KIND_STRD);
    half = (r.op_kind == elsdu_pkg::KIND_STRH || r.op_kind == elsdu_pkg::KIND_LDRH ||
            r.op_kind == elsdu_pkg::KIND_LDRSH);
    rt2 = dbl ? rt + 4'd1 : 4'd0;
    r.dest_reg = rt;
    r.dest2_reg = rt2;
    r.base_reg = rn;
    // PC-relative loads are flagged and not executed; stores with Rn = PC are.
    if (immf && rn == elsdu_pkg::REG_PC && r.op_kind != elsdu_pkg::KIND_STRH &&
        r.op_kind != elsdu_pkg::KIND_STRD) begin
      r.literal_form = 1'b1;
      return r;
    end
    off = immf ? {24'h0, ins[11:8], rm} : w.index_value;
    oaddr = up ? w.base_value + off : w.base_value - off;
    addr = pre ? oaddr : w.base_value;
    wback = !pre || wbit;
    if (dbl) begin
      unp = rt[0] || (!pre && wbit) || rt2 == elsdu_pkg::REG_PC;
      if (wback && (rn == rt || rn == rt2)) unp = 1'b1;
      if (wback && rn == elsdu_pkg::REG_PC) unp = 1'b1;
      if (!immf) begin
        if (rm == elsdu_pkg::REG_PC) unp = 1'b1;
        if (r.op_kind == elsdu_pkg::KIND_LDRD && (rm == rt || rm == rt2)) unp = 1'b1;
      end
      fault = addr[1:0] != 2'b00;
    end else begin
      unp = (rt == elsdu_pkg::REG_PC) || (wback && rn == rt);
      if (wback && rn == elsdu_pkg::REG_PC) unp = 1'b1;
      if (!immf && rm == elsdu_pkg::REG_PC) unp = 1'b1;
      fault = half && !uok && addr[0];
    end
    if (!immf && v6 && wback && rm == rn) unp = 1'b1;
    r.execute = w.cond_passed;
    r.address = addr;
    r.second_address = dbl ? addr + elsdu_pkg::DWORD_STEP : 32'h0;
    r.writeback = w.cond_passed && wback;
    r.writeback_value = oaddr;
    r.unpredictable = w.cond_passed && unp;
    r.align_fault = w.cond_passed && fault;
    return r;
  endfunction

  function automatic string fmt_result(elsdu_pkg::result_t r);
    return $sformatf(
      {"kind=%0d ex=%0b addr=%h addr2=%h rt=%0d rt2=%0d rn=%0d wb=%0b wbv=%h ",
       "unp=%0b flt=%0b lit=%0b"},
      r.op_kind, r.execute, r.address, r.second_address, r.dest_reg, r.dest2_reg,
      r.base_reg, r.writeback, r.writeback_value, r.unpredictable, r.align_fault,
      r.literal_form);
  endfunction

  // Encodes a well-formed extra load/store word with condition AL.
  // For register forms low8 holds bits 11:8 (normally zero) and Rm.
  function automatic logic [31:0] make_word(logic [1:0] op2, logic ld, logic immf,
                                            logic pre, logic up, logic wbit,
                                            logic [3:0] rn, logic [3:0] rt,
                                            logic [7:0] low8);
    return {4'hE, 3'b000, pre, up, immf, wbit, ld, rn, rt, low8[7:4], 1'b1, op2, 1'b1,
            low8[3:0]};
  endfunction

  function automatic logic [31:0] pick_operand();
    case ($urandom_range(3))
      0:       return 32'($urandom_range(15));
      1:       return 32'hFFFF_FFF0 | 32'($urandom_range(15));
      2:       return $urandom & 32'hFFFF_FFFC;
      default: return $urandom;
    endcase
  endfunction

  function automatic insn_word_t random_word();
    insn_word_t w;
    logic [3:0] rn, rt, rm, hi4;
    logic [1:0] op2;
    logic       immf;
    int         shape;
    shape = $urandom_range(99);
    rn = ($urandom_range(5) == 0) ? elsdu_pkg::REG_PC : 4'($urandom);
    rt = ($urandom_range(7) == 0) ? elsdu_pkg::REG_PC : 4'($urandom);
    rm = ($urandom_range(7) == 0) ? elsdu_pkg::REG_PC : 4'($urandom);
    if ($urandom_range(4) == 0) rn = rt;
    if ($urandom_range(4) == 0) rm = rn;
    if ($urandom_range(6) == 0) rm = rt;
    op2 = 2'($urandom_range(3, 1));
    immf = 1'($urandom);
    hi4 = (immf || $urandom_range(15) == 0) ? 4'($urandom) : 4'h0;
    w.instr = {4'($urandom), 3'b000, 2'($urandom), immf, 2'($urandom), rn, rt, hi4,
               1'b1, op2, 1'b1, rm};
    // A small share of noise: arbitrary words and words with one bit flipped.
    if (shape < 8)
      w.instr = $urandom;
    else if (shape < 15)
      w.instr = w.instr ^ (32'h1 << $urandom_range(31));
    w.cond_passed = $urandom_range(9) != 0;
    w.base_value = pick_operand();
    w.index_value = pick_operand();
    return w;
  endfunction

  task automatic add_word(logic [31:0] instr, logic cond_passed, logic [31:0] base_value,
                          logic [31:0] index_value);
    pending_words.push_back('{instr, cond_passed, base_value, index_value});
  endtask

  task automatic write_config(logic uok, logic v6);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= elsdu_pkg::CFG_UNALIGNED_OK;
    cfg_wdata <= uok;
    @(posedge clk);
    cfg_index <= elsdu_pkg::CFG_ARCH_BEFORE_V6;
    cfg_wdata <= v6;
    @(posedge clk);
    cfg_we <= 1'b0;
    model_uok = uok;
    model_v6 = v6;
    repeat (2) @(negedge clk);
  endtask

  // Waits until every queued word is taken and every result has come back.
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_words.size() != 0 || in_ch.valid || expected_decodes.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic run_phase(int send_pct, int recv_pct, int count, logic uok, logic v6,
                           logic with_hold);
    write_config(uok, v6);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    repeat (count) pending_words.push_back(random_word());
    if (with_hold) begin
      hold_start = 1'b1;
      @(negedge clk);
      hold_start = 1'b0;
    end
    wait_drained();
  endtask

  // Driver: offers the next pending word and keeps it until it is taken.
  always @(posedge clk) begin
    elsdu_pkg::result_t pred;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        pred = decode_access(in_flight, model_uok, model_v6);
        expected_decodes.push_back(pred);
        words_accepted++;
        kind_tally[int'(pred.op_kind)]++;
        if (pred.unpredictable) unp_tally++;
        if (pred.align_fault) fault_tally++;
        if (pred.literal_form) literal_tally++;
      end
      if (in_ch.valid && !in_ch.ready) begin
        input_stall_cycles++;
      end else if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_flight = pending_words.pop_front();
        in_ch.instr <= in_flight.instr;
        in_ch.cond_passed <= in_flight.cond_passed;
        in_ch.base_value <= in_flight.base_value;
        in_ch.index_value <= in_flight.index_value;
        in_ch.valid <= 1'b1;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Long output hold-off so that both stages fill and the input stalls.
  always @(posedge clk) begin
    if (!rst_n)
      hold_left <= 0;
    else if (hold_start)
      hold_left <= HOLD_LEN;
    else if (hold_left != 0)
      hold_left <= hold_left - 1;
  end

  // Monitor: checks each result word against the oldest expectation.
  always @(posedge clk) begin
    elsdu_pkg::result_t got, want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got.op_kind = out_ch.op_kind;
        got.execute = out_ch.execute;
        got.address = out_ch.address;
        got.second_address = out_ch.second_address;
        got.dest_reg = out_ch.dest_reg;
        got.dest2_reg = out_ch.dest2_reg;
        got.base_reg = out_ch.base_reg;
        got.writeback = out_ch.writeback;
        got.writeback_value = out_ch.writeback_value;
        got.unpredictable = out_ch.unpredictable;
        got.align_fault = out_ch.align_fault;
        got.literal_form = out_ch.literal_form;
        if (expected_decodes.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%t: unexpected result word: %s", $realtime, fmt_result(got));
        end else begin
          want = expected_decodes.pop_front();
          results_checked++;
          if (got !== want) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("%t: mismatch on result %0d", $realtime, results_checked);
              $display("  expected %s", fmt_result(want));
              $display("  actual   %s", fmt_result(got));
            end
          end
        end
      end
      out_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    #5ms;
    $display("Timeout with %0d results still expected", expected_decodes.size());
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = elsdu_pkg::CFG_UNALIGNED_OK;
    cfg_wdata = 1'b0;
    hold_start = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    model_uok = 1'b1;
    model_v6 = 1'b0;
    fail_count = 0;
    words_accepted = 0;
    results_checked = 0;
    input_stall_cycles = 0;
    unp_tally = 0;
    fault_tally = 0;
    literal_tally = 0;
    foreach (kind_tally[k]) kind_tally[k] = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    write_config(1'b1, 1'b0);
    // Directed corner cases under the reset settings.
    add_word(make_word(elsdu_pkg::OP2_HALF, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0,
                       4'd1, 4'd2, 8'h34), 1'b1, 32'h0000_1000, 32'h0);
    add_word(make_word(elsdu_pkg::OP2_HALF, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0,
                       4'd3, 4'd4, 8'h05), 1'b1, 32'hFFFF_FFFF, 32'h1);
    add_word(make_word(elsdu_pkg::OP2_DBL_SB, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1,
                       4'd5, 4'd3, 8'h00), 1'b1, 32'h2, 32'h0);
    add_word(make_word(elsdu_pkg::OP2_DBL_SB, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0,
                       4'd6, 4'd7, 8'h08), 1'b1, 32'h0, 32'hFFFF_FFFF);
    add_word(make_word(elsdu_pkg::OP2_DBL_SH, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0,
                       4'd2, 4'd14, 8'h01), 1'b1, 32'h100, 32'h4);
    add_word(make_word(elsdu_pkg::OP2_DBL_SH, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0,
                       4'd8, 4'd9, 8'h01), 1'b1, 32'h1000, 32'h0);
    add_word(make_word(elsdu_pkg::OP2_HALF, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0,
                       elsdu_pkg::REG_PC, 4'd1, 8'hFF), 1'b1, 32'h1234_5678, 32'h0);
    add_word(make_word(elsdu_pkg::OP2_DBL_SB, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1,
                       elsdu_pkg::REG_PC, 4'd2, 8'h10), 1'b1, 32'h8000, 32'h0);
    add_word(make_word(elsdu_pkg::OP2_HALF, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1,
                       elsdu_pkg::REG_PC, 4'd3, 8'h02), 1'b1, 32'h4000, 32'h0);
    add_word(make_word(elsdu_pkg::OP2_DBL_SH, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0,
                       4'd4, 4'd5, 8'h03), 1'b0, 32'h2001, 32'h0);
    add_word(make_word(elsdu_pkg::OP2_NONE, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0,
                       4'd1, 4'd2, 8'h11), 1'b1, 32'h10, 32'h0);
    add_word(make_word(elsdu_pkg::OP2_HALF, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0,
                       4'd1, 4'd2, 8'h11) | 32'h0200_0000, 1'b1, 32'h10, 32'h0);
    add_word(make_word(elsdu_pkg::OP2_HALF, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0,
                       4'd1, 4'd2, 8'h11) & ~32'h80, 1'b1, 32'h10, 32'h0);
    add_word(make_word(elsdu_pkg::OP2_HALF, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0,
                       4'd1, 4'd2, 8'h11) & ~32'h10, 1'b1, 32'h10, 32'h0);
    add_word(make_word(elsdu_pkg::OP2_HALF, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0,
                       4'd1, 4'd2, 8'hA3), 1'b1, 32'h10, 32'h5);
    add_word(make_word(elsdu_pkg::OP2_DBL_SB, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0,
                       4'd1, 4'd4, 8'h04), 1'b1, 32'h40, 32'h8);
    add_word(make_word(elsdu_pkg::OP2_HALF, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0,
                       4'd2, elsdu_pkg::REG_PC, 8'h00), 1'b1, 32'h20, 32'h0);
    add_word(make_word(elsdu_pkg::OP2_DBL_SH, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1,
                       4'd3, 4'd6, 8'h08), 1'b1, 32'h30, 32'h0);
    add_word(make_word(elsdu_pkg::OP2_HALF, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1,
                       4'd7, 4'd8, 8'h07), 1'b1, 32'h50, 32'h3);
    add_word(32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_word(32'h0000_0000, 1'b0, 32'h0, 32'h0);
    add_word(make_word(elsdu_pkg::OP2_DBL_SH, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0,
                       4'd9, 4'd10, 8'hFF), 1'b1, 32'h0, 32'h0);
    add_word(make_word(elsdu_pkg::OP2_DBL_SH, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0,
                       4'd1, 4'd2, 8'h0F), 1'b1, 32'h8, 32'h10);
    add_word(make_word(elsdu_pkg::OP2_DBL_SB, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0,
                       4'd5, 4'd5, 8'h02), 1'b1, 32'h60, 32'h1);
    wait_drained();

    run_phase(0, 0, 238, 1'b1, 1'b0, 1'b1);
    run_phase(82, 0, 238, 1'b0, 1'b0, 1'b0);
    run_phase(0, 82, 238, 1'b0, 1'b1, 1'b0);
    run_phase(15, 15, 238, 1'b1, 1'b1, 1'b0);

    repeat (10) @(negedge clk);
    fail_count += expected_decodes.size();
    $display("Checked %0d results from %0d words; input held off for %0d cycles.",
             results_checked, words_accepted, input_stall_cycles);
    $display("Kinds err/strh/ldrh/ldrd/ldrsb/strd/ldrsh: %0d/%0d/%0d/%0d/%0d/%0d/%0d",
             kind_tally[0], kind_tally[1], kind_tally[2], kind_tally[3], kind_tally[4],
             kind_tally[5], kind_tally[6]);
    $display("Unpredictable/fault/literal: %0d/%0d/%0d", unp_tally, fault_tally,
             literal_tally);
    if (fail_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
